// File: rtl/core/mf12_pkg.sv
// ----------------------------------------------------------------------------
// mf12_pkg: shared types, constants and helpers for the 1-4-7 minifloat unit
// decodes operand fields and rounds an exact magnitude to the 12-bit format
// ----------------------------------------------------------------------------
package mf12_pkg;

  localparam logic [11:0] MF_NAN  = 12'h788;
  localparam logic [11:0] MF_INF  = 12'h780;
  localparam logic [11:0] MF_SIGN = 12'h800;
  localparam logic [6:0]  MF_FRAC = 7'h7F;
  localparam logic [3:0]  MF_EXP_MAX = 4'hF;

  // exact add magnitude: 8-bit mantissa shifted by up to 13, plus carry
  localparam int MAG_W = 22;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NEG = 2'd3
  } mf_op_t;

  typedef struct packed {
    logic       sign;
    logic       is_zero;
    logic       is_inf;
    logic       is_nan;
    logic [7:0] mant;     // hidden one plus fraction, zero for a zero operand
    logic [3:0] exp_eff;  // zero operand takes exponent 1
  } mf_fields_t;

  function automatic mf_fields_t mf_decode(logic [11:0] v);
    mf_fields_t f;
    f.sign    = v[11];
    f.is_zero = (v[10:7] == 4'd0);
    f.is_inf  = (v[10:7] == MF_EXP_MAX) && (v[6:0] == 7'd0);
    f.is_nan  = (v[10:7] == MF_EXP_MAX) && (v[6:0] != 7'd0);
    f.mant    = f.is_zero ? 8'd0 : {1'b1, v[6:0]};
    f.exp_eff = f.is_zero ? 4'd1 : v[10:7];
    return f;
  endfunction

  // round sign * mag * 2^scale (mag nonzero) to nearest-even
  function automatic logic [11:0] mf_round(logic s, logic [MAG_W-1:0] mag,
                                           logic signed [6:0] scale);
    logic [4:0]       p;
    logic [MAG_W-1:0] norm;
    logic [8:0]       mant;
    logic             guard;
    logic             sticky;
    logic signed [7:0] ex;
    logic [11:0]      res;
    p = 5'd0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag[i]) begin
        p = 5'(i);
      end
    end
    norm   = mag << (5'(MAG_W - 1) - p);
    mant   = {1'b0, norm[MAG_W-1 -: 8]};
    guard  = norm[MAG_W-9];
    sticky = |norm[MAG_W-10:0];
    if (guard && (sticky || norm[MAG_W-8])) begin
      mant = mant + 9'd1;
    end
    ex = $signed({3'b000, p}) + $signed({scale[6], scale}) + 8'sd7;
    if (mant[8]) begin
      ex = ex + 8'sd1;
    end
    if (ex >= 8'sd15) begin
      res = {s, MF_INF[10:0]};
    end else if (ex <= 8'sd0) begin
      res = {s, 11'd0};
    end else begin
      res = {s, ex[3:0], (mant[8] ? 7'd0 : mant[6:0])};
    end
    return res;
  endfunction

endpackage

// File: rtl/core/minifloat12_add_sub_mul_top.sv
// ----------------------------------------------------------------------------
// minifloat12_add_sub_mul_top: 1-4-7 minifloat add / subtract / multiply / negate
// one operation per transaction, exact result rounded to nearest-even
// ----------------------------------------------------------------------------
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+------------------------
//  input    | in_operation, in_operand_a, in_operand_b       | start && !busy
//  result   | out_result                                     | out_valid, one cycle
//
//  an accepted transaction is latched in the operand register, goes through one
//  pass of combinational float logic and lands in the result register, with
//  out_valid registered alongside the result
//  a new transaction is taken every cycle
//  busy stays low: nothing in the datapath holds a transaction back
//  synchronous active-low reset clears the valid flags only
//  the receiver cannot stall; each result shows for exactly one cycle
//
module minifloat12_add_sub_mul_top
  import mf12_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_operand_a,
  input  logic [11:0] in_operand_b,
  output logic        out_valid,
  output logic [11:0] out_result
);

  // operand register
  logic        vld_in_r;
  logic [1:0]  op_r;
  logic [11:0] a_r;
  logic [11:0] b_r;

  // result register
  logic        out_valid_r;
  logic [11:0] result_r;
  logic [11:0] result_nxt;

  // decoded operands
  mf_fields_t fa;
  mf_fields_t fb;
  mf_op_t     op;

  // adder datapath
  logic             sb_add;      // b sign after subtract flip
  logic             a_hi;        // a has the larger (or equal) exponent
  logic [3:0]       exp_diff;
  logic [3:0]       exp_min;
  logic [MAG_W-1:0] x_hi;
  logic [MAG_W-1:0] x_lo;
  logic             s_hi;
  logic             s_lo;
  logic [MAG_W-1:0] add_mag;
  logic             add_sign;
  logic [11:0]      add_res;
  logic signed [6:0] add_scale;

  // multiplier datapath
  logic             mul_sign;
  logic [15:0]      prod;
  logic signed [6:0] mul_scale;
  logic [11:0]      mul_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_in_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_in_r    <= start && !busy;
      out_valid_r <= vld_in_r;
    end
    // payload registers run without reset
    if (start && !busy) begin
      op_r <= in_operation;
      a_r  <= in_operand_a;
      b_r  <= in_operand_b;
    end
    result_r <= result_nxt;
  end

  always_comb begin
    fa = mf_decode(a_r);
    fb = mf_decode(b_r);
    op = mf_op_t'(op_r);

    // ---- add / subtract: align smaller exponent side, exact sum ----
    sb_add   = (op == OP_SUB) ? ~fb.sign : fb.sign;
    a_hi     = (fa.exp_eff >= fb.exp_eff);
    exp_diff = a_hi ? (fa.exp_eff - fb.exp_eff) : (fb.exp_eff - fa.exp_eff);
    exp_min  = a_hi ? fb.exp_eff : fa.exp_eff;
    x_hi     = MAG_W'(a_hi ? fa.mant : fb.mant) << exp_diff;
    x_lo     = MAG_W'(a_hi ? fb.mant : fa.mant);
    s_hi     = a_hi ? fa.sign : sb_add;
    s_lo     = a_hi ? sb_add : fa.sign;
    if (s_hi == s_lo) begin
      add_mag  = x_hi + x_lo;
      add_sign = s_hi;
    end else if (x_hi >= x_lo) begin
      add_mag  = x_hi - x_lo;
      add_sign = s_hi;
    end else begin
      add_mag  = x_lo - x_hi;
      add_sign = s_lo;
    end
    add_scale = $signed({3'b000, exp_min}) - 7'sd14;

    priority if (fa.is_nan || fb.is_nan) begin
      add_res = MF_NAN;
    end else if (fa.is_inf && fb.is_inf) begin
      add_res = (fa.sign != sb_add) ? MF_NAN : {fa.sign, MF_INF[10:0]};
    end else if (fa.is_inf) begin
      add_res = {fa.sign, MF_INF[10:0]};
    end else if (fb.is_inf) begin
      add_res = {sb_add, MF_INF[10:0]};
    end else if (add_mag == '0) begin
      // like-signed zeros keep their sign, exact cancellation gives +0
      add_res = (s_hi == s_lo) ? {s_hi, 11'd0} : 12'd0;
    end else begin
      add_res = mf_round(add_sign, add_mag, add_scale);
    end

    // ---- multiply: 8x8 mantissa product ----
    mul_sign  = fa.sign ^ fb.sign;
    prod      = fa.mant * fb.mant;
    mul_scale = $signed({3'b000, fa.exp_eff}) + $signed({3'b000, fb.exp_eff}) - 7'sd28;

    priority if (fa.is_nan || fb.is_nan) begin
      mul_res = {mul_sign, MF_NAN[10:0]};
    end else if ((fa.is_zero && fb.is_inf) || (fb.is_zero && fa.is_inf)) begin
      mul_res = MF_NAN;
    end else if (fa.is_inf || fb.is_inf) begin
      mul_res = {mul_sign, MF_INF[10:0]};
    end else if (fa.is_zero || fb.is_zero) begin
      mul_res = {mul_sign, 11'd0};
    end else begin
      mul_res = mf_round(mul_sign, MAG_W'(prod), mul_scale);
    end

    unique case (op)
      OP_ADD, OP_SUB: result_nxt = add_res;
      OP_MUL:         result_nxt = mul_res;
      OP_NEG:         result_nxt = a_r ^ MF_SIGN;
      default:        result_nxt = a_r ^ MF_SIGN;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  // ---- assertions ----

  // every accepted transaction yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // no result appears without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ##1 !out_valid)
    else $error("result strobe without an accepted transaction");

  // negate only flips the sign bit of operand a
  a_negate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start, 2) && ($past(in_operation, 2) == OP_NEG))
      |-> (out_result == ($past(in_operand_a, 2) ^ MF_SIGN)))
    else $error("negate result mismatch");

endmodule
